// ===== rtl/chebyshev_clenshaw_eval_defines.svh =====
// ----------------------------------------------------------------------------
// Chebyshev Clenshaw evaluator assertion macros
// Shared assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef CHEBYSHEV_CLENSHAW_EVAL_DEFINES_SVH
`define CHEBYSHEV_CLENSHAW_EVAL_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define CCE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define CCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cce_pkg.sv =====
// ----------------------------------------------------------------------------
// cce_pkg
// Widths, codes and shared types of the Chebyshev Clenshaw evaluator.
// ----------------------------------------------------------------------------
package cce_pkg;

  localparam int MAX_TERMS_DEF = 64;
  localparam int IDX_W         = 6;
  localparam int DATA_W        = 32;
  localparam int THR_W         = 31;
  localparam int ADDR_W        = 4;
  localparam int SQ_W          = 61;   // radicand 2^60 - x^2
  localparam int ROOT_W        = 31;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  typedef enum logic [1:0] {
    REG_TOP_INDEX = 2'd0,
    REG_ODD_ORDER = 2'd1,
    REG_ZERO_THR  = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_STEP_A,
    S_STEP_B,
    S_FIN_A,
    S_FIN_B,
    S_ODD_W,
    S_ODD_B,
    S_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

// ===== rtl/chebyshev_clenshaw_eval.sv =====
// ----------------------------------------------------------------------------
// chebyshev_clenshaw_eval
// Chebyshev series evaluator: Clenshaw recurrence on a shared multiplier.
// ----------------------------------------------------------------------------
// Input stream: tuser is the command. A load request writes one Q8.24
// coefficient into the store, taken every cycle while idle; it gives no result.
// An evaluate request carries x (Q2.30) and gives one result on the output
// stream: tdata is the Q8.24 value, tuser the saturation flag.
// An evaluate request holds the block for the accept cycle, the x*x product,
// a multiply then an add per recurrence step, the final sum and the hand-over
// of the result. With odd_order set the square-root unit runs beside the
// recurrence; the odd factor then waits for the root and is applied before
// the hand-over. The multiply-then-add loop over the coefficient memory sets
// the worst case.
// in_tready is low while an evaluation runs.
// A finished result sits in the output register; if the receiver stalls, the
// block holds the next result back and accepts nothing until it is taken.
// Reset clears the configuration and the control; the coefficient store is not
// cleared, so every coefficient up to top_index must be loaded before use.
// ----------------------------------------------------------------------------
module chebyshev_clenshaw_eval #(
  parameter int MAX_TERMS = cce_pkg::MAX_TERMS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [71:0]                  in_tdata,   // coef_index, coef_value, x, pad
  input  logic                         in_tuser,   // command
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [31:0]                  out_tdata,  // value
  output logic                         out_tuser,  // saturated
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [cce_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);

  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam logic [31:0]   TERMS_U = 32'(MAX_TERMS);
  localparam logic [AW-1:0] TOP_MAX = AW'(MAX_TERMS - 1);
  localparam logic signed [65:0] RND28 = 66'sd268435456;
  localparam logic signed [65:0] RND29 = 66'sd536870912;
  localparam logic signed [65:0] ONE60 = 66'sd1152921504606846976;
  localparam logic signed [65:0] POS_MAX = 66'sd2147483647;
  localparam logic signed [65:0] NEG_MIN = -66'sd2147483648;

  typedef struct packed {
    logic signed [31:0] val;
    logic               ovf;
  } sat_t;

  function automatic sat_t sat32(input logic signed [65:0] v);
    sat_t s;
    if (v > POS_MAX) begin
      s.val = 32'sh7FFFFFFF;
      s.ovf = 1'b1;
    end else if (v < NEG_MIN) begin
      s.val = 32'sh80000000;
      s.ovf = 1'b1;
    end else begin
      s.val = v[31:0];
      s.ovf = 1'b0;
    end
    return s;
  endfunction

  // configuration
  logic [cce_pkg::IDX_W-1:0] top_index_r;
  logic                      odd_order_r;
  logic [cce_pkg::THR_W-1:0] zero_thr_r;
  logic                      cfg_wr;
  cce_pkg::reg_idx_t         cfg_sel;

  // request fields
  logic                      in_cmd;
  logic [cce_pkg::IDX_W-1:0] in_idx;
  logic signed [31:0]        in_coef;
  logic signed [31:0]        in_x;
  logic                      in_take;

  // sequencer and datapath
  cce_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]        j_r;
  logic [AW-1:0]        top_eff;
  logic [AW-1:0]        rd_addr;
  logic signed [31:0]   x_r, d_r, dd_r, res_r, coef_r;
  logic                 flag_r;
  logic                 sq_go_r;
  logic signed [31:0]   coef_mem [MAX_TERMS];

  logic signed [31:0]   mul_a, mul_b;
  logic signed [63:0]   prod_r;
  logic signed [65:0]   p_ext, d2_ext, c_ext;
  logic signed [65:0]   rad_diff;
  logic [cce_pkg::SQ_W-1:0]   radicand;
  logic [cce_pkg::ROOT_W-1:0] root;
  cce_pkg::sqrt_stat_t        sq_stat;
  sat_t                 step_s, fin_s, odd_s;

  // output
  logic                 out_valid_r;
  logic [31:0]          out_data_r;
  logic                 out_flag_r;
  logic                 out_load;
  logic [32:0]          mag;

  assign in_cmd  = in_tuser;
  assign in_idx  = in_tdata[5:0];
  assign in_coef = $signed(in_tdata[37:6]);
  assign in_x    = $signed(in_tdata[69:38]);
  assign in_take = in_tvalid && in_tready;

  // ---- configuration port ----
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = cce_pkg::reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_index_r <= '0;
      odd_order_r <= 1'b0;
      zero_thr_r  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        cce_pkg::REG_TOP_INDEX: top_index_r <= cfg_pwdata[cce_pkg::IDX_W-1:0];
        cce_pkg::REG_ODD_ORDER: odd_order_r <= cfg_pwdata[0];
        cce_pkg::REG_ZERO_THR:  zero_thr_r  <= cfg_pwdata[cce_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      cce_pkg::REG_TOP_INDEX: cfg_prdata = {26'd0, top_index_r};
      cce_pkg::REG_ODD_ORDER: cfg_prdata = {31'd0, odd_order_r};
      cce_pkg::REG_ZERO_THR:  cfg_prdata = {1'b0, zero_thr_r};
      default:                cfg_prdata = '0;
    endcase
  end

  // top index clamped to the store depth
  assign top_eff = ({26'd0, top_index_r} >= TERMS_U) ? TOP_MAX : AW'(top_index_r);

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cce_pkg::S_IDLE;
      sq_go_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sq_go_r <= (state_r == cce_pkg::S_SQ);
    end
  end

  assign out_load = (state_r == cce_pkg::S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    rd_addr   = j_r;
    mul_a     = x_r;
    mul_b     = d_r;
    unique case (state_r)
      cce_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && in_cmd == cce_pkg::CMD_EVAL) state_nxt = cce_pkg::S_SQ;
      end
      cce_pkg::S_SQ: begin
        mul_b     = x_r;
        state_nxt = (j_r == '0) ? cce_pkg::S_FIN_A : cce_pkg::S_STEP_A;
      end
      cce_pkg::S_STEP_A: state_nxt = cce_pkg::S_STEP_B;
      cce_pkg::S_STEP_B: begin
        state_nxt = (j_r == AW'(1)) ? cce_pkg::S_FIN_A : cce_pkg::S_STEP_A;
      end
      cce_pkg::S_FIN_A: begin
        rd_addr   = '0;
        state_nxt = cce_pkg::S_FIN_B;
      end
      cce_pkg::S_FIN_B: begin
        state_nxt = odd_order_r ? cce_pkg::S_ODD_W : cce_pkg::S_DONE;
      end
      cce_pkg::S_ODD_W: begin
        mul_a = res_r;
        mul_b = $signed({1'b0, root});
        if (sq_stat.done) state_nxt = cce_pkg::S_ODD_B;
      end
      cce_pkg::S_ODD_B: state_nxt = cce_pkg::S_DONE;
      cce_pkg::S_DONE: begin
        if (out_load) state_nxt = cce_pkg::S_IDLE;
      end
      default: state_nxt = cce_pkg::S_IDLE;
    endcase
  end

  // ---- shared units ----
  cce_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  // x*x sits in the product register in the cycle after S_SQ
  assign rad_diff = ONE60 - p_ext;
  assign radicand = rad_diff[65] ? '0 : rad_diff[cce_pkg::SQ_W-1:0];

  cce_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_go_r),
    .radicand (radicand),
    .root     (root),
    .stat     (sq_stat)
  );

  // ---- arithmetic after the multiplier ----
  assign p_ext  = {{2{prod_r[63]}}, prod_r};
  assign d2_ext = {{34{dd_r[31]}}, dd_r};
  assign c_ext  = {{34{coef_r[31]}}, coef_r};

  assign step_s = sat32(((p_ext + RND28) >>> 29) - d2_ext + c_ext);
  assign fin_s  = sat32((p_ext - (d2_ext <<< 30) + (c_ext <<< 29) + RND29) >>> 30);
  assign odd_s  = sat32((p_ext + RND29) >>> 30);

  // ---- coefficient store ----
  always_ff @(posedge clk) begin
    if (in_take && in_cmd == cce_pkg::CMD_LOAD && {26'd0, in_idx} < TERMS_U) begin
      coef_mem[AW'(in_idx)] <= in_coef;
    end
    coef_r <= coef_mem[rd_addr];
  end

  // ---- recurrence registers ----
  always_ff @(posedge clk) begin
    case (state_r)
      cce_pkg::S_IDLE: begin
        if (in_take && in_cmd == cce_pkg::CMD_EVAL) begin
          x_r    <= in_x;
          j_r    <= top_eff;
          d_r    <= '0;
          dd_r   <= '0;
          flag_r <= 1'b0;
        end
      end
      cce_pkg::S_STEP_B: begin
        d_r    <= step_s.val;
        dd_r   <= d_r;
        j_r    <= j_r - AW'(1);
        flag_r <= flag_r | step_s.ovf;
      end
      cce_pkg::S_FIN_B: begin
        res_r  <= fin_s.val;
        flag_r <= flag_r | fin_s.ovf;
      end
      cce_pkg::S_ODD_B: begin
        res_r  <= odd_s.val;
        flag_r <= flag_r | odd_s.ovf;
      end
      default: ;
    endcase
  end

  // ---- output register ----
  assign mag = res_r[31] ? (33'd0 - {1'b1, res_r}) : {1'b0, res_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= (mag < {2'b00, zero_thr_r}) ? '0 : res_r;
      out_flag_r <= flag_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_flag_r;

endmodule

// ===== rtl/cce_mul.sv =====
// ----------------------------------------------------------------------------
// cce_mul
// Shared signed 32x32 multiplier with a registered product.
// ----------------------------------------------------------------------------
module cce_mul (
  input  logic                                clk,
  input  logic signed [cce_pkg::DATA_W-1:0]   mul_a,
  input  logic signed [cce_pkg::DATA_W-1:0]   mul_b,
  output logic signed [2*cce_pkg::DATA_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule

// ===== rtl/cce_sqrt.sv =====
// ----------------------------------------------------------------------------
// cce_sqrt
// Bit-pair restoring integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module cce_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [cce_pkg::SQ_W-1:0]     radicand,
  output logic [cce_pkg::ROOT_W-1:0]   root,
  output cce_pkg::sqrt_stat_t          stat
);

  localparam logic [cce_pkg::SQ_W-1:0] BIT_TOP = {1'b1, {(cce_pkg::SQ_W-1){1'b0}}};

  logic [cce_pkg::SQ_W-1:0] rem_r;
  logic [cce_pkg::SQ_W:0]   res_r;
  logic [cce_pkg::SQ_W-1:0] bit_r;
  logic                     busy_r;
  logic                     done_r;
  logic [cce_pkg::SQ_W:0]   trial;
  logic                     take;

  assign trial = res_r + {1'b0, bit_r};
  assign take  = {1'b0, rem_r} >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && bit_r[0]) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= radicand;
      res_r <= '0;
      bit_r <= BIT_TOP;
    end else if (busy_r) begin
      if (take) begin
        rem_r <= rem_r - trial[cce_pkg::SQ_W-1:0];
        res_r <= (res_r >> 1) + {1'b0, bit_r};
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign root = res_r[cce_pkg::ROOT_W-1:0];
  assign stat = '{busy: busy_r, done: done_r};

endmodule

// ===== rtl/cce_checker.sv =====
// ----------------------------------------------------------------------------
// cce_checker
// Port-level checks of the Chebyshev Clenshaw evaluator, bound to the top.
// ----------------------------------------------------------------------------
`include "chebyshev_clenshaw_eval_defines.svh"

module cce_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  // a stalled result holds
  `CCE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // an evaluate request closes the input while it runs
  `CCE_ASSERT_NEXT(a_eval_busy, clk, rst_n,
    in_tvalid && in_tready && in_tuser == cce_pkg::CMD_EVAL, !in_tready,
    "input open during evaluation")

  // loads never stall the input
  `CCE_ASSERT_NEXT(a_load_open, clk, rst_n,
    in_tvalid && in_tready && in_tuser == cce_pkg::CMD_LOAD, in_tready,
    "input closed after a load")

  // a new result only appears at the end of an evaluation
  `CCE_ASSERT_NOW(a_out_src, clk, rst_n, $rose(out_tvalid), !$past(in_tready),
    "result without an evaluation")

endmodule

bind chebyshev_clenshaw_eval cce_checker u_cce_checker (.*);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: chebyshev_clenshaw_eval regression
// Loads coefficients and evaluates the Clenshaw series over a range of
// register settings. Each accepted evaluate request goes through a local
// fixed-point predictor, and every result is checked against the oldest
// predicted value. Idle and stall patterns vary per phase, and one phase
// holds the output off long enough to back-pressure the input.
// ----------------------------------------------------------------------------
module tb;

  localparam int NSLOTS        = 64;
  localparam int SETTLE_CYCLES = 200;     // above the worst evaluate latency
  localparam int DRAIN_LIMIT   = 500000;
  localparam int HOLD_CYCLES   = 400;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_ITEMS   = 120;
  localparam int MAX_REPORTS   = 20;

  typedef struct packed {
    logic        cmd;
    logic [5:0]  idx;
    logic [31:0] coef;
    logic [31:0] x;
  } cheb_req_t;

  typedef struct packed {
    logic [31:0] value;
    logic        sat;
  } series_out_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;     // coef_index, coef_value, x, pad
  logic        in_tuser = 1'b0;   // command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // value
  logic        out_tuser;         // saturated
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [cce_pkg::ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  chebyshev_clenshaw_eval dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the block's state
  logic signed [31:0] coef_mem [NSLOTS];
  logic [5:0]  top_sel = '0;
  logic        odd_sel = 1'b0;
  logic [30:0] zthr = '0;

  cheb_req_t   pending_reqs [$];
  series_out_t expected_sums [$];
  cheb_req_t   cur_req;

  int gap_pct = 0;
  int stall_pct = 0;
  bit hold_phase_on = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  int err_count = 0;
  int load_count = 0;
  int eval_count = 0;
  int checked_count = 0;
  int sat_count = 0;
  int zero_count = 0;
  int setting_count = 0;

  function automatic longint q824_clip(input longint v, inout bit flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint root_floor(input longint a);
    longint root, cand;
    root = 0;
    for (int i = 30; i >= 0; i--) begin
      cand = root | (longint'(1) << i);
      if (cand * cand <= a) root = cand;
    end
    return root;
  endfunction

  function automatic series_out_t clenshaw_series(input logic signed [31:0] xin);
    longint xv, d, dd, nd, t, acc, r, q, res, mag;
    bit flag;
    series_out_t o;
    flag = 1'b0;
    xv = xin;
    d = 0;
    dd = 0;
    for (int j = top_sel; j >= 1; j--) begin
      t = (xv * d + (longint'(1) << 28)) >>> 29;
      nd = q824_clip(t - dd + longint'(coef_mem[j]), flag);
      dd = d;
      d = nd;
    end
    // final sum kept exact at 54 fraction bits before rounding
    acc = xv * d - dd * (longint'(1) << 30) + longint'(coef_mem[0]) * (longint'(1) << 29);
    res = q824_clip((acc + (longint'(1) << 29)) >>> 30, flag);
    if (odd_sel) begin
      r = (longint'(1) << 60) - xv * xv;
      if (r < 0) r = 0;
      q = root_floor(r);
      res = q824_clip((res * q + (longint'(1) << 29)) >>> 30, flag);
    end
    mag = (res < 0) ? -res : res;
    if (mag < longint'(zthr)) res = 0;
    o.value = res[31:0];
    o.sat = flag;
    return o;
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (cur_req.cmd == cce_pkg::CMD_LOAD) begin
          coef_mem[cur_req.idx] = cur_req.coef;
          load_count++;
        end else begin
          expected_sums.push_back(clenshaw_series(cur_req.x));
          eval_count++;
        end
      end
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99, 0) >= gap_pct) begin
          cur_req = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {2'b00, cur_req.x, cur_req.coef, cur_req.idx};
          in_tuser <= cur_req.cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long output hold-off, counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_phase_on && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    series_out_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_sums.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: result with nothing predicted: value %h saturated %b",
                     $time, out_tdata, out_tuser);
        end else begin
          want = expected_sums.pop_front();
          checked_count++;
          if (want.sat) sat_count++;
          if (want.value == '0) zero_count++;
          if (out_tdata !== want.value) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("%0t: value mismatch: expected %h actual %h",
                       $time, want.value, out_tdata);
          end
          if (out_tuser !== want.sat) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("%0t: saturated flag mismatch: expected %b actual %b",
                       $time, want.sat, out_tuser);
          end
        end
      end
      out_tready <= (hold_left == 0) && ($urandom_range(99, 0) >= stall_pct);
    end
  end

  task automatic cfg_write(input cce_pkg::reg_idx_t r, input logic [31:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {r, 2'b00};
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (r)
      cce_pkg::REG_TOP_INDEX: top_sel = v[5:0];
      cce_pkg::REG_ODD_ORDER: odd_sel = v[0];
      cce_pkg::REG_ZERO_THR:  zthr = v[30:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int t, input bit o, input logic [30:0] z);
    cfg_write(cce_pkg::REG_TOP_INDEX, t);
    cfg_write(cce_pkg::REG_ODD_ORDER, {31'b0, o});
    cfg_write(cce_pkg::REG_ZERO_THR, {1'b0, z});
    setting_count++;
  endtask

  function automatic void push_load(input logic [5:0] idx, input logic [31:0] v);
    cheb_req_t r;
    r.cmd = cce_pkg::CMD_LOAD;
    r.idx = idx;
    r.coef = v;
    r.x = $urandom;
    pending_reqs.push_back(r);
  endfunction

  function automatic void push_eval(input logic [31:0] xv);
    cheb_req_t r;
    r.cmd = cce_pkg::CMD_EVAL;
    r.idx = 6'($urandom);
    r.coef = $urandom;
    r.x = xv;
    pending_reqs.push_back(r);
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(3, 0))
      0: return $urandom;
      1, 2: return $urandom_range(32'h0200_0000, 0) - 32'h0100_0000;
      default: return $urandom_range(32'h0002_0000, 0) - 32'h0001_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_point();
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 85) return $urandom_range(32'h8000_0000, 0) - 32'h4000_0000;
    if (pick < 90) begin
      case ($urandom_range(2, 0))
        0: return 32'h4000_0000;
        1: return 32'hC000_0000;
        default: return 32'h0;
      endcase
    end
    return $urandom;   // often outside [-1,1]
  endfunction

  task automatic settle();
    int guard;
    guard = 0;
    while ((pending_reqs.size() != 0 || in_tvalid || expected_sums.size() != 0)
           && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    // loads give no result, so let the last request work through
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int t;
    bit o;
    logic [30:0] z;
    int mode;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // recurrence saturation, ends of the point range, points outside
    apply_settings(3, 1'b0, '0);
    push_load(0, 32'h7FFF_FFFF);
    push_load(1, 32'h8000_0000);
    push_load(2, 32'h0100_0000);
    push_load(3, 32'hFFFF_FFFF);
    push_eval(32'h4000_0000);
    push_eval(32'hC000_0000);
    push_eval(32'h0000_0000);
    push_eval(32'h7FFF_FFFF);
    push_eval(32'h8000_0000);
    settle();

    // odd factor with everything zeroed; saturation flag must survive
    apply_settings(1, 1'b1, 31'h7FFF_FFFF);
    push_load(0, 32'h7FFF_FFFF);
    push_load(1, 32'h7FFF_FFFF);
    push_eval(32'h4000_0000);
    push_eval(32'h2000_0000);
    push_eval(32'h8000_0000);
    settle();

    // no recurrence steps, threshold around the odd factor's output
    apply_settings(0, 1'b1, 31'h0080_0000);
    push_load(0, 32'h0200_0000);
    push_eval(32'h0000_0000);
    push_eval(32'h3800_0000);
    push_eval(32'hC000_0000);
    settle();

    for (int p = 1; p <= RAND_PHASES; p++) begin
      case (p)
        1: begin t = 63; o = 1'b0; z = '0; mode = 0; end
        2: begin t = $urandom_range(8, 1); o = 1'b1; z = '0; mode = 1; end
        3: begin t = 0; o = 1'b1; z = 31'($urandom_range(32'h0100_0000, 0)); mode = 2; end
        4: begin t = 2; o = 1'b0; z = '0; mode = 0; end
        5: begin t = $urandom_range(63, 0); o = 1'($urandom); z = 31'h7FFF_FFFF; mode = 3; end
        6: begin t = 63; o = 1'b1; z = 31'($urandom_range(32'h0001_0000, 0)); mode = 1; end
        7: begin
          t = $urandom_range(63, 0);
          o = 1'($urandom);
          z = 31'($urandom_range(32'h0040_0000, 0));
          mode = 2;
        end
        default: begin t = $urandom_range(15, 0); o = 1'b0; z = '0; mode = 3; end
      endcase
      apply_settings(t, o, z);
      case (mode)
        1: begin gap_pct = 58; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 58; end
        3: begin gap_pct = 32; stall_pct = 32; end
        default: begin gap_pct = 0; stall_pct = 0; end
      endcase
      // every slot written before any deep evaluation
      if (p == 1)
        for (int s = 0; s < NSLOTS; s++) push_load(6'(s), rand_coef());
      hold_phase_on = (p == 4);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(99, 0) < 35) push_load(6'($urandom_range(63, 0)), rand_coef());
        else push_eval(rand_point());
      end
      settle();
    end
    hold_phase_on = 1'b0;

    if (expected_sums.size() != 0) begin
      $display("%0t: %0d predicted results never arrived", $time, expected_sums.size());
      err_count += expected_sums.size();
    end
    $display("covered %0d coefficient loads and %0d evaluations over %0d register settings",
             load_count, eval_count, setting_count);
    $display("%0d results checked, %0d saturated, %0d zero, one %0d-cycle output hold-off",
             checked_count, sat_count, zero_count, HOLD_CYCLES);
    if (err_count == 0) begin
      $display("chebyshev_clenshaw_eval regression: pass");
    end else begin
      $display("chebyshev_clenshaw_eval regression: fail");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("chebyshev_clenshaw_eval regression: fail");
    $finish;
  end

endmodule
